FILE: rtl/rke_pkg.sv
package rke_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned KeyWidth   = 8;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	localparam logic [KeyWidth-1:0] KEY_DIGIT_LO = 8'h30; // '0'
	localparam logic [KeyWidth-1:0] KEY_DIGIT_HI = 8'h39; // '9'
	localparam logic [KeyWidth-1:0] KEY_ALPHA_LO = 8'h61; // 'a'
	localparam logic [KeyWidth-1:0] KEY_ALPHA_HI = 8'h66; // 'f'
	localparam logic [KeyWidth-1:0] KEY_BACK     = 8'h6D; // 'm'
	localparam logic [KeyWidth-1:0] KEY_SEL_DEC  = 8'h2C; // ','
	localparam logic [KeyWidth-1:0] KEY_SEL_HEX  = 8'h2E; // '.'
	localparam logic [KeyWidth-1:0] KEY_SEL_BIN  = 8'h2F; // '/'

	// floor(x / 10) == (x * RECIP10) >> 35 for every 32-bit x
	localparam logic [ValueWidth-1:0] RECIP10  = 32'hCCCC_CCCD;
	localparam int unsigned           Recip10Shift = 35;

	// outcome of one key against the current state
	typedef struct packed {
		logic                  hit;
		logic [ValueWidth-1:0] value;
		radix_t                radix;
	} rke_next_t;

endpackage

FILE: rtl/rke_stream_if.sv
interface rke_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink   (input valid, input key_code, output ready);
endinterface

interface rke_entry_if;
	logic        valid;
	logic        ready;
	logic [31:0] entry_value;
	logic [1:0]  radix_mode;

	modport source (output valid, output entry_value, output radix_mode, input ready);
	modport sink   (input valid, input entry_value, input radix_mode, output ready);
endinterface

FILE: rtl/rke_step.sv
module rke_step
	import rke_pkg::*;
(
	input  logic [ValueWidth-1:0] value,
	input  radix_t                radix,
	input  logic [KeyWidth-1:0]   key_code,
	output rke_next_t             nxt
);

	logic                  is_num;
	logic                  is_alpha;
	logic [3:0]            digit;
	logic [4:0]            base;
	logic [ValueWidth+3:0] scaled;
	logic [ValueWidth+4:0] sum;
	logic                  append_ok;
	logic [2*ValueWidth-1:0] prod10;
	logic [ValueWidth-1:0] dropped;
	logic [ValueWidth-1:0] appended;

	assign is_num   = (key_code >= KEY_DIGIT_LO) && (key_code <= KEY_DIGIT_HI);
	assign is_alpha = (key_code >= KEY_ALPHA_LO) && (key_code <= KEY_ALPHA_HI);

	always_comb begin
		if (is_alpha) begin
			digit = 4'((key_code - KEY_ALPHA_LO) + 8'd10);
		end else begin
			digit = 4'(key_code - KEY_DIGIT_LO);
		end
	end

	// value * radix, shift-add only
	always_comb begin
		unique case (radix)
			RADIX_HEX: begin
				base   = 5'd16;
				scaled = {value, 4'b0000};
			end
			RADIX_BIN: begin
				base   = 5'd2;
				scaled = {3'b000, value, 1'b0};
			end
			default: begin
				base   = 5'd10;
				scaled = {1'b0, value, 3'b000} + {3'b000, value, 1'b0};
			end
		endcase
	end

	assign sum       = {1'b0, scaled} + {{(ValueWidth+1){1'b0}}, digit};
	// refuse digits out of range and anything past the top of the value
	assign append_ok = ({1'b0, digit} < base) && (sum[ValueWidth+4:ValueWidth] == 5'd0);
	assign appended  = append_ok ? sum[ValueWidth-1:0] : value;

	assign prod10 = {{ValueWidth{1'b0}}, value} * {{ValueWidth{1'b0}}, RECIP10};

	always_comb begin
		unique case (radix)
			RADIX_HEX: dropped = value >> 4;
			RADIX_BIN: dropped = value >> 1;
			default:   dropped = ValueWidth'(prod10[2*ValueWidth-1:Recip10Shift]);
		endcase
	end

	always_comb begin
		nxt.hit   = 1'b1;
		nxt.value = value;
		nxt.radix = radix;
		priority if (is_num || is_alpha) begin
			nxt.value = appended;
		end else if (key_code == KEY_BACK) begin
			nxt.value = dropped;
		end else if (key_code == KEY_SEL_DEC) begin
			nxt.radix = RADIX_DEC;
		end else if (key_code == KEY_SEL_HEX) begin
			nxt.radix = RADIX_HEX;
		end else if (key_code == KEY_SEL_BIN) begin
			nxt.radix = RADIX_BIN;
		end else begin
			nxt.hit = 1'b0;
		end
	end

endmodule

FILE: rtl/radix_keypad_entry_register_core.sv
// channel | dir | modport | payload                         | transaction when
// --------+-----+---------+---------------------------------+------------------
// key     | in  | sink    | key_code[7:0]                   | valid && ready
// entry   | out | source  | entry_value[31:0], radix_mode[1:0] | valid && ready
//
// One key per cycle while entry is not stalled; a recognized key passes from its
// transaction into the input register, then the result register, and shows on entry.
// The per-key update (multiply-add append or divide-by-radix backspace) is
// combinational between the input register and the state/result registers.
// arst_n clears value to 0, mode to decimal and both valid flags.
// A stalled entry holds its result; the input register keeps taking keys until
// it holds a recognized key that cannot move on. Unrecognized keys drain freely.
module radix_keypad_entry_register_core
	import rke_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	rke_key_if.sink            key,
	rke_entry_if.source        entry
);

	// input register
	logic                  valid_s1;
	logic [KeyWidth-1:0]   key_s1;

	// architectural state
	logic [ValueWidth-1:0] value_q;
	radix_t                radix_q;

	// result register
	logic                  out_valid_q;
	logic [ValueWidth-1:0] out_value_q;
	radix_t                out_radix_q;

	rke_next_t             nxt;
	logic                  fire_s1;
	logic                  take_in;

	rke_step u_step (
		.value    (value_q),
		.radix    (radix_q),
		.key_code (key_s1),
		.nxt      (nxt)
	);

	// s1 advances when its key produces nothing, or the result slot is free
	// or being emptied this cycle
	assign fire_s1 = valid_s1 && (!nxt.hit || !out_valid_q || entry.ready);
	assign take_in = !valid_s1 || fire_s1;

	assign key.ready = take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in && key.valid) begin
			key_s1 <= key.key_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			radix_q <= RADIX_DEC;
		end else if (fire_s1 && nxt.hit) begin
			value_q <= nxt.value;
			radix_q <= nxt.radix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && nxt.hit) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && nxt.hit) begin
			out_value_q <= nxt.value;
			out_radix_q <= nxt.radix;
		end
	end

	assign entry.valid       = out_valid_q;
	assign entry.entry_value = out_value_q;
	assign entry.radix_mode  = 2'(out_radix_q);

endmodule

FILE: rtl/rke_checker.sv
module rke_checker
	import rke_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  key_valid,
	input logic                  key_ready,
	input logic [KeyWidth-1:0]   key_code,
	input logic                  ent_valid,
	input logic                  ent_ready,
	input logic [ValueWidth-1:0] entry_value,
	input logic [1:0]            radix_mode
);

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ent_valid && !ent_ready |=> ent_valid && $stable(entry_value) && $stable(radix_mode))
		else $error("entry changed while stalled");

	// mode code 3 is never produced
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ent_valid |-> radix_mode != 2'd3)
		else $error("illegal radix mode on entry");

	// a select or backspace key shows up (or something ahead of it is still pending)
	a_key_latency: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready && (key_code == KEY_SEL_DEC || key_code == KEY_SEL_HEX ||
		key_code == KEY_SEL_BIN || key_code == KEY_BACK) |=> ##1 ent_valid)
		else $error("recognized key produced no entry");

	// nothing is offered while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !ent_valid)
		else $error("entry valid during reset");

endmodule

bind radix_keypad_entry_register_core rke_checker u_rke_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.key_valid   (key.valid),
	.key_ready   (key.ready),
	.key_code    (key.key_code),
	.ent_valid   (entry.valid),
	.ent_ready   (entry.ready),
	.entry_value (entry.entry_value),
	.radix_mode  (entry.radix_mode)
);

FILE: dv/rke_entry_checker.sv
`timescale 1ns / 1ps

module rke_entry_checker
	import rke_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	rke_key_if    key,
	rke_entry_if  entry,
	output int    mismatch_cnt,
	output int    pending_cnt
);

	logic [ValueWidth-1:0] entry_value_q;
	radix_t                radix_q;
	rke_next_t             expected_entries[$];

	// next value/mode after one key; hit is low for keys the block ignores
	function automatic rke_next_t next_entry_state(logic [ValueWidth-1:0] value,
			radix_t mode, logic [KeyWidth-1:0] k);
		rke_next_t   nx;
		logic [4:0]  base;
		logic [4:0]  digit;
		logic        is_digit;
		logic [63:0] wide;
		nx.hit   = 1'b1;
		nx.value = value;
		nx.radix = mode;
		is_digit = 1'b0;
		digit    = '0;
		case (mode)
			RADIX_HEX: base = 5'd16;
			RADIX_BIN: base = 5'd2;
			default:   base = 5'd10;
		endcase
		if (k >= KEY_DIGIT_LO && k <= KEY_DIGIT_HI) begin
			is_digit = 1'b1;
			digit    = 5'(k - KEY_DIGIT_LO);
		end else if (k >= KEY_ALPHA_LO && k <= KEY_ALPHA_HI) begin
			is_digit = 1'b1;
			digit    = 5'(k - KEY_ALPHA_LO) + 5'd10;
		end else if (k == KEY_BACK) begin
			case (mode)
				RADIX_BIN: nx.value = value >> 1;
				RADIX_HEX: nx.value = value >> 4;
				default:   nx.value = value / 10;
			endcase
		end else if (k == KEY_SEL_DEC) begin
			nx.radix = RADIX_DEC;
		end else if (k == KEY_SEL_HEX) begin
			nx.radix = RADIX_HEX;
		end else if (k == KEY_SEL_BIN) begin
			nx.radix = RADIX_BIN;
		end else begin
			nx.hit = 1'b0;
		end
		// out-of-radix digit or overflow: key refused, value kept
		if (is_digit && digit < base) begin
			wide = {32'd0, value} * 64'(base) + 64'(digit);
			if (wide <= 64'h0000_0000_FFFF_FFFF)
				nx.value = wide[ValueWidth-1:0];
		end
		return nx;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rke_next_t want;
		rke_next_t nx;
		if (!arst_n) begin
			entry_value_q = '0;
			radix_q       = RADIX_DEC;
			expected_entries.delete();
			mismatch_cnt  = 0;
			pending_cnt  <= 0;
		end else begin
			// results leave only after passing the input and result registers, so retire before predicting
			if (entry.valid && entry.ready) begin
				if (expected_entries.size() == 0) begin
					$error("entry: unexpected transaction, value %0h mode %0d",
						entry.entry_value, entry.radix_mode);
					mismatch_cnt++;
				end else begin
					want = expected_entries.pop_front();
					if (entry.entry_value !== want.value) begin
						$error("entry_value: expected %0h, got %0h", want.value,
							entry.entry_value);
						mismatch_cnt++;
					end
					if (entry.radix_mode !== want.radix) begin
						$error("radix_mode: expected %0d, got %0d", want.radix,
							entry.radix_mode);
						mismatch_cnt++;
					end
				end
			end
			if (key.valid && key.ready) begin
				nx = next_entry_state(entry_value_q, radix_q, key.key_code);
				if (nx.hit) begin
					entry_value_q = nx.value;
					radix_q       = nx.radix;
					expected_entries.push_back(nx);
				end
			end
			pending_cnt <= expected_entries.size();
		end
	end

endmodule

FILE: dv/tb_radix_keypad_entry_register_core.sv
`timescale 1ns / 1ps

module tb_radix_keypad_entry_register_core;
	import rke_pkg::*;

	// keys the block must ignore
	localparam logic [KeyWidth-1:0] KEY_QUIT    = 8'h71; // 'q'
	localparam logic [KeyWidth-1:0] KEY_UPPER_A = 8'h41; // 'A'

	localparam int NumBlocks   = 8;
	localparam int KeysInBlock = 90;

	logic clk;
	logic arst_n;

	rke_key_if   key_ch();
	rke_entry_if entry_ch();

	int mismatch_cnt;
	int pending_cnt;

	// idle/stall odds in percent, switched per phase
	int idle_pct  = 0;
	int stall_pct = 0;
	int keys_sent = 0;

	logic [KeyWidth-1:0] directed_keys [26];

	radix_keypad_entry_register_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.entry  (entry_ch)
	);

	rke_entry_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.key          (key_ch),
		.entry        (entry_ch),
		.mismatch_cnt (mismatch_cnt),
		.pending_cnt  (pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: random backpressure on the entry channel
	always @(posedge clk) begin
		entry_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop; far beyond the slowest legal run (~750 keys, worst gaps)
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// one key transaction; random idle cycles in front of it.
	// valid stays high on return so keys can go back to back.
	task automatic send_key(input logic [KeyWidth-1:0] k);
		while ($urandom_range(99) < idle_pct) begin
			key_ch.valid <= 1'b0;
			@(posedge clk);
		end
		key_ch.valid    <= 1'b1;
		key_ch.key_code <= k;
		@(posedge clk);
		while (!key_ch.ready)
			@(posedge clk);
		keys_sent++;
	endtask

	// stop sending and wait until every predicted entry has been seen.
	// pending_cnt is registered, hence the wait for a clock edge before the first look.
	task automatic drain_entries();
		key_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
	endtask

	// run of digits, often long enough to overflow; binary needs 32+ digits
	task automatic send_digit_run();
		int                  n;
		int                  kind;
		logic [KeyWidth-1:0] d;
		kind = $urandom_range(2);
		n    = (kind == 2) ? $urandom_range(20, 40) : $urandom_range(8, 14);
		repeat (n) begin
			case (kind)
				0:       d = KEY_DIGIT_LO + 8'($urandom_range(9));
				1:       d = KEY_ALPHA_LO + 8'($urandom_range(5));
				default: d = KEY_DIGIT_LO + 8'($urandom_range(1));
			endcase
			send_key(d);
		end
	endtask

	// mostly legal keys, some raw noise across the full byte range
	function automatic logic [KeyWidth-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return KEY_DIGIT_LO + 8'($urandom_range(9));
		else if (r < 50)
			return KEY_ALPHA_LO + 8'($urandom_range(5));
		else if (r < 64)
			return KEY_BACK;
		else if (r < 78) begin
			case ($urandom_range(2))
				0:       return KEY_SEL_DEC;
				1:       return KEY_SEL_HEX;
				default: return KEY_SEL_BIN;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	initial begin
		key_ch.valid    = 1'b0;
		key_ch.key_code = '0;
		entry_ch.ready  = 1'b0;
		arst_n          = 1'b0;

		// ignored codes, decimal digit/letter/backspace (incl. backspace at 0),
		// binary with out-of-radix digit, hex filled until digits are refused
		// (overflow), backspace in hex, back to decimal
		directed_keys = '{8'h00, 8'hFF, KEY_QUIT, KEY_UPPER_A,
			KEY_DIGIT_HI, KEY_ALPHA_LO, KEY_BACK, KEY_BACK,
			KEY_SEL_BIN, KEY_DIGIT_LO + 8'd1, KEY_DIGIT_LO + 8'd2, KEY_DIGIT_LO,
			KEY_BACK, KEY_SEL_HEX,
			KEY_ALPHA_HI, KEY_ALPHA_HI, KEY_ALPHA_HI, KEY_ALPHA_HI,
			KEY_ALPHA_HI, KEY_ALPHA_HI, KEY_ALPHA_HI, KEY_ALPHA_HI,
			KEY_ALPHA_HI, KEY_DIGIT_LO, KEY_BACK, KEY_SEL_DEC};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed keys at full rate
		foreach (directed_keys[i])
			send_key(directed_keys[i]);
		drain_entries();

		// random phases: none, sender idle, receiver stall, both
		for (int blk = 0; blk < NumBlocks; blk++) begin
			case (blk % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 84; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			keys_sent = 0;
			while (keys_sent < KeysInBlock) begin
				if ($urandom_range(99) < 6)
					send_digit_run();
				else
					send_key(pick_key());
			end
			// sender holds off mid-run until the pipe is empty
			if (blk == 3)
				drain_entries();
		end

		idle_pct  = 0;
		stall_pct = 0;
		drain_entries();
		// let the clock run on to catch stray transactions
		repeat (8) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rke_pkg.sv
rtl/rke_stream_if.sv
rtl/rke_step.sv
rtl/radix_keypad_entry_register_core.sv
rtl/rke_checker.sv
dv/rke_entry_checker.sv
dv/tb_radix_keypad_entry_register_core.sv
